// File: rtl/core/api_pkg.sv
// alarm priority indication: shared types and constants
// no dependencies; used by the step engine, the top level and the checker
`timescale 1ns / 1ps

package api_pkg;

  // alarm levels
  localparam logic [1:0] LVL_NONE   = 2'd0;
  localparam logic [1:0] LVL_LOW    = 2'd1;
  localparam logic [1:0] LVL_MEDIUM = 2'd2;
  localparam logic [1:0] LVL_HIGH   = 2'd3;

  // buzzer commands beyond the plain levels
  localparam logic [2:0] BUZ_OFF     = 3'd0;
  localparam logic [2:0] BUZ_INHIBIT = 3'd4;

  localparam logic [1:0] LED_OFF = 2'd0;

  // boost timer codes
  localparam logic [16:0] TMR_EXPIRED = 17'h00000;
  localparam logic [16:0] TMR_STOPPED = 17'h10000;

  // register indexes on the configuration port
  localparam logic [1:0] REG_INHIBIT_PERIODS = 2'd0;
  localparam logic [1:0] REG_BOOST_PERIODS   = 2'd1;
  localparam logic [1:0] REG_USER_SOUND      = 2'd2;
  localparam logic [1:0] REG_MAX_SOUND       = 2'd3;

  typedef struct packed {
    logic [15:0] inhibit_periods;
    logic [15:0] boost_periods;
    logic [2:0]  user_sound_level;
    logic [2:0]  max_sound_level;
  } cfg_t;

  // input beat, last member in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic        start_stop_busy;
    logic [3:0]  vent_mode;
    logic        display_dismissed;
    logic        uncancel_request;
    logic        turbine_overheat;
    logic        battery_end;
    logic        keyboard_fault;
    logic        cancel_request;
    logic [15:0] low_word;
    logic [47:0] medium_words;
    logic [47:0] high_words;
  } in_item_t;

  // result beat, last member in the lowest bits
  typedef struct packed {
    logic        buzzer_reinit;
    logic [2:0]  sound_level;
    logic        inhibit_event;
    logic        inhibited_display;
    logic [1:0]  led_cmd;
    logic [2:0]  buzzer_cmd;
    logic        new_high_alarm;
    logic        new_alarm;
    logic        any_alarm;
    logic [1:0]  prio_level;
  } res_t;

endpackage

// File: rtl/core/alarm_priority_indication.sv
// alarm priority indication: top level with stream ports and register port
// depends on api_pkg and api_engine
`timescale 1ns / 1ps

// One input beat is one scheduling period of the alarm manager: the high,
// medium and low alarm words plus key and fault flags. For each beat the
// block gives exactly one result beat with the top alarm level, new-alarm
// flags, the held buzzer and LED commands, the inhibit indication and event,
// the selected sound level and a volume reload pulse. A beat is taken every
// clock cycle unless the result register is stalled with the input register
// full; each beat passes the input register and then the result register
// that sit around the combinational step logic. All timer state is
// counted in beats, not clocks.
// The four registers (inhibit periods, boost periods, user and max sound
// level) lie at byte addresses 0, 4, 8 and 12 and should only be written
// while no beat is in flight. There is no clearing pass after reset.

module alarm_priority_indication #(
  parameter int WORD_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // high_words[47:0], medium_words[95:48], low_word[111:96],
  // cancel_request[112], keyboard_fault[113], battery_end[114],
  // turbine_overheat[115], uncancel_request[116], display_dismissed[117],
  // vent_mode[121:118], start_stop_busy[122], zero[127:123]
  input  logic [127:0] in_tdata,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // prio_level[1:0], any_alarm[2], new_alarm[3], new_high_alarm[4],
  // buzzer_cmd[7:5], led_cmd[9:8], inhibited_display[10], inhibit_event[11],
  // sound_level[14:12], buzzer_reinit[15]
  output logic [15:0]  out_tdata,
  // register port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  api_pkg::cfg_t     cfg_r;
  api_pkg::in_item_t s1_item_r;
  logic              s1_valid_r;
  api_pkg::res_t     res_nxt;
  api_pkg::res_t     out_res_r;
  logic              out_valid_r;

  logic       out_free;   // result register can load this cycle
  logic       step;       // beat in the input register moves to the result
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // register port: no wait states
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inhibit_periods  <= 16'd60;
      cfg_r.boost_periods    <= 16'd60;
      cfg_r.user_sound_level <= 3'd3;
      cfg_r.max_sound_level  <= 3'd7;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        api_pkg::REG_INHIBIT_PERIODS: cfg_r.inhibit_periods  <= cfg_pwdata[15:0];
        api_pkg::REG_BOOST_PERIODS:   cfg_r.boost_periods    <= cfg_pwdata[15:0];
        api_pkg::REG_USER_SOUND:      cfg_r.user_sound_level <= cfg_pwdata[2:0];
        api_pkg::REG_MAX_SOUND:       cfg_r.max_sound_level  <= cfg_pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      api_pkg::REG_INHIBIT_PERIODS: cfg_prdata = {16'd0, cfg_r.inhibit_periods};
      api_pkg::REG_BOOST_PERIODS:   cfg_prdata = {16'd0, cfg_r.boost_periods};
      api_pkg::REG_USER_SOUND:      cfg_prdata = {29'd0, cfg_r.user_sound_level};
      api_pkg::REG_MAX_SOUND:       cfg_prdata = {29'd0, cfg_r.max_sound_level};
      default:                      cfg_prdata = '0;
    endcase
  end

  // two-stage flow: input register, then result register
  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (out_free)  out_valid_r <= s1_valid_r;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_item_r <= api_pkg::in_item_t'(in_tdata);
    if (step) out_res_r <= res_nxt;
  end

  // period state advances once per beat that reaches the result register
  api_engine #(
    .WORD_BITS (WORD_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .res     (res_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

endmodule

// File: rtl/core/api_engine.sv
// alarm priority indication: per-period step logic and its state
// depends on api_pkg
`timescale 1ns / 1ps

module api_engine #(
  parameter int WORD_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  api_pkg::in_item_t item,
  input  api_pkg::cfg_t     cfg,
  output api_pkg::res_t     res
);

  localparam logic [47:0] THREE_MASK = (48'd1 << (3 * WORD_BITS)) - 48'd1;
  localparam logic [15:0] ONE_MASK   = (16'd1 << WORD_BITS) - 16'd1;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_DETECTED,
    ST_INHIBITED
  } ind_state_t;

  logic [47:0] prev_high_r, prev_high_nxt;
  logic [47:0] prev_medium_r, prev_medium_nxt;
  logic [15:0] prev_low_r, prev_low_nxt;
  logic [1:0]  prev_level_r, prev_level_nxt;
  ind_state_t  state_r, state_nxt;
  logic        inhibited_r, inhibited_nxt;
  logic        boost_mutex_r, boost_mutex_nxt;
  logic        boost_active_r, boost_active_nxt;
  logic [16:0] boost_timer_r, boost_timer_nxt;
  logic [15:0] inhibit_timer_r, inhibit_timer_nxt;
  logic [3:0]  last_mode_r, last_mode_nxt;
  logic        mode_seen_r, mode_seen_nxt;
  logic [2:0]  buzzer_r, buzzer_nxt;
  logic [1:0]  led_r, led_nxt;

  logic [47:0] hi, me;
  logic [15:0] lo;
  logic [1:0]  level;
  logic        detected, new_hi, new_any, inhib, event_p, reinit;
  logic        mode_change, restore;
  logic [2:0]  sound_start;
  logic [16:0] bt_dec;
  logic [15:0] it_dec;
  logic [3:0]  mode_ref;

  always_comb begin
    hi = item.high_words & THREE_MASK;
    me = item.medium_words & THREE_MASK;
    lo = item.low_word & ONE_MASK;

    // timers count down before they are read
    bt_dec = ((boost_timer_r != api_pkg::TMR_EXPIRED) && (boost_timer_r != api_pkg::TMR_STOPPED))
           ? boost_timer_r - 17'd1 : boost_timer_r;
    it_dec = (inhibit_timer_r != 16'd0) ? inhibit_timer_r - 16'd1 : inhibit_timer_r;

    mode_ref    = mode_seen_r ? last_mode_r : item.vent_mode;
    mode_change = mode_ref != item.vent_mode;
    sound_start = boost_active_r ? cfg.max_sound_level : cfg.user_sound_level;

    boost_active_nxt = boost_active_r;
    boost_mutex_nxt  = boost_mutex_r;
    boost_timer_nxt  = bt_dec;
    inhibit_timer_nxt = it_dec;
    inhibited_nxt    = inhibited_r;
    buzzer_nxt       = buzzer_r;
    led_nxt          = led_r;
    state_nxt        = state_r;
    reinit           = 1'b0;
    inhib            = 1'b0;
    event_p          = 1'b0;

    // level, and volume restore once the high alarm is gone
    restore = (hi == '0) && (sound_start == cfg.max_sound_level)
              && (prev_level_r == api_pkg::LVL_HIGH);
    if (restore) begin
      boost_active_nxt = 1'b0;
      reinit = 1'b1;
    end
    if (hi != '0)      level = api_pkg::LVL_HIGH;
    else if (me != '0) level = api_pkg::LVL_MEDIUM;
    else if (lo != '0) level = api_pkg::LVL_LOW;
    else               level = api_pkg::LVL_NONE;
    detected = level != api_pkg::LVL_NONE;

    // rising bits against the previous period
    new_hi  = (hi & ~prev_high_r) != '0;
    new_any = new_hi || ((me & ~prev_medium_r) != '0) || ((lo & ~prev_low_r) != '0);
    if (new_any) inhibited_nxt = 1'b0;

    // cancel key
    if (item.cancel_request && !item.keyboard_fault) begin
      if (detected && !item.battery_end && !item.turbine_overheat) begin
        inhib = 1'b1;
        inhibited_nxt = 1'b1;
        event_p = 1'b1;
        boost_active_nxt = 1'b0;
      end
    end else if (!detected) begin
      inhibited_nxt = 1'b0;
    end

    // boost management
    if (new_hi && ((bt_dec == api_pkg::TMR_EXPIRED) || (bt_dec == api_pkg::TMR_STOPPED))) begin
      boost_timer_nxt = {1'b0, cfg.boost_periods};
      boost_mutex_nxt = 1'b0;
    end else if (((level != api_pkg::LVL_HIGH) && (prev_level_r == api_pkg::LVL_HIGH))
                 || mode_change) begin
      boost_timer_nxt  = api_pkg::TMR_STOPPED;
      boost_active_nxt = 1'b0;
      reinit = 1'b1;
    end else if ((bt_dec == api_pkg::TMR_EXPIRED) && (level == api_pkg::LVL_HIGH)
                 && !inhib && !boost_mutex_r) begin
      boost_active_nxt = 1'b1;
      buzzer_nxt = api_pkg::BUZ_OFF;
      reinit = 1'b1;
      boost_mutex_nxt = 1'b1;
    end

    // indication machine
    unique case (state_r)
      ST_NONE: begin
        if (detected) begin
          state_nxt = ST_DETECTED;
        end else begin
          buzzer_nxt = api_pkg::BUZ_OFF;
          led_nxt = api_pkg::LED_OFF;
        end
      end
      ST_DETECTED: begin
        buzzer_nxt = {1'b0, level};
        led_nxt = level;
        if (!detected) begin
          state_nxt = ST_NONE;
        end else if (inhib) begin
          state_nxt = ST_INHIBITED;
          inhibit_timer_nxt = cfg.inhibit_periods;
        end
      end
      ST_INHIBITED: begin
        buzzer_nxt = api_pkg::BUZ_INHIBIT;
        if (item.display_dismissed && !inhibited_r) begin
          if (!detected) led_nxt = api_pkg::LED_OFF;
        end else begin
          led_nxt = level;
        end
        if (!detected) begin
          state_nxt = ST_NONE;
        end else if (new_any || (it_dec == 16'd0) || item.uncancel_request) begin
          state_nxt = ST_DETECTED;
          inhibited_nxt = 1'b0;
          if (level == api_pkg::LVL_HIGH) begin
            boost_timer_nxt = {1'b0, cfg.boost_periods};
            boost_mutex_nxt = 1'b0;
          end
          reinit = 1'b1;
          boost_active_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (item.start_stop_busy) buzzer_nxt = api_pkg::BUZ_INHIBIT;

    prev_high_nxt   = hi;
    prev_medium_nxt = me;
    prev_low_nxt    = lo;
    prev_level_nxt  = level;
    last_mode_nxt   = item.vent_mode;
    mode_seen_nxt   = 1'b1;

    res.prio_level        = level;
    res.any_alarm         = detected;
    res.new_alarm         = new_any;
    res.new_high_alarm    = new_hi;
    res.buzzer_cmd        = buzzer_nxt;
    res.led_cmd           = led_nxt;
    res.inhibited_display = inhibited_nxt;
    res.inhibit_event     = event_p;
    res.sound_level       = boost_active_nxt ? cfg.max_sound_level : cfg.user_sound_level;
    res.buzzer_reinit     = reinit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_high_r     <= '0;
      prev_medium_r   <= '0;
      prev_low_r      <= '0;
      prev_level_r    <= api_pkg::LVL_NONE;
      state_r         <= ST_NONE;
      inhibited_r     <= 1'b0;
      boost_mutex_r   <= 1'b0;
      boost_active_r  <= 1'b0;
      boost_timer_r   <= api_pkg::TMR_EXPIRED;
      inhibit_timer_r <= '0;
      last_mode_r     <= '0;
      mode_seen_r     <= 1'b0;
      buzzer_r        <= api_pkg::BUZ_OFF;
      led_r           <= api_pkg::LED_OFF;
    end else if (step_en) begin
      prev_high_r     <= prev_high_nxt;
      prev_medium_r   <= prev_medium_nxt;
      prev_low_r      <= prev_low_nxt;
      prev_level_r    <= prev_level_nxt;
      state_r         <= state_nxt;
      inhibited_r     <= inhibited_nxt;
      boost_mutex_r   <= boost_mutex_nxt;
      boost_active_r  <= boost_active_nxt;
      boost_timer_r   <= boost_timer_nxt;
      inhibit_timer_r <= inhibit_timer_nxt;
      last_mode_r     <= last_mode_nxt;
      mode_seen_r     <= mode_seen_nxt;
      buzzer_r        <= buzzer_nxt;
      led_r           <= led_nxt;
    end
  end

endmodule

// File: rtl/core/api_checker.sv
// alarm priority indication: port-level checks and their bind
// depends on api_pkg; attaches to alarm_priority_indication
`timescale 1ns / 1ps

module api_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        cfg_pready
);

  api_pkg::res_t res;
  logic          out_beat;

  assign res      = api_pkg::res_t'(out_tdata);
  assign out_beat = out_tvalid && out_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // detected flag agrees with the level
  a_detect_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> (res.any_alarm == (res.prio_level != api_pkg::LVL_NONE)))
    else $error("any_alarm disagrees with prio_level");

  // a new high alarm is a new alarm at high level
  a_new_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && res.new_high_alarm |-> res.new_alarm
      && (res.prio_level == api_pkg::LVL_HIGH))
    else $error("new_high_alarm without high level or new_alarm");

  // inhibition is only accepted with an alarm present
  a_event_detect: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && res.inhibit_event |-> res.any_alarm)
    else $error("inhibit_event without alarm");

  // register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("cfg_pready low");

endmodule

bind alarm_priority_indication api_checker u_api_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

// File: tb/sv/alarm_priority_indication_tb.sv
// testbench for alarm_priority_indication: directed rows then random periods,
// every result beat checked against an in-bench model or a hand-written result
// depends on api_pkg and the alarm_priority_indication rtl
`timescale 1ns / 1ps

module alarm_priority_indication_tb;

  localparam int N_DIR       = 20;
  localparam int N_PHASES    = 6;
  localparam int PHASE_BEATS = 214;
  localparam int LONG_HOLD   = 200;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_GAP     = 12;
  localparam int DRAIN_PAD   = 4;

  // key and flag masks for the directed rows
  localparam logic [5:0] K_CANCEL   = 6'h01;
  localparam logic [5:0] K_KBFAULT  = 6'h02;
  localparam logic [5:0] K_BATTERY  = 6'h04;
  localparam logic [5:0] K_OVERHEAT = 6'h08;
  localparam logic [5:0] K_UNCANCEL = 6'h10;
  localparam logic [5:0] K_DISMISS  = 6'h20;
  localparam logic [5:0] K_ALL      = 6'h3F;

  localparam logic [47:0] ALL_WORDS = 48'hFFFF_FFFF_FFFF;

  // indication machine states
  typedef enum logic [1:0] {
    IND_IDLE  = 2'd0,
    IND_ALERT = 2'd1,
    IND_MUTED = 2'd2
  } ind_state_t;

  // one directed row: stimulus, and a hand-written result where it is obvious
  typedef struct packed {
    logic [47:0]   hi;
    logic [47:0]   me;
    logic [15:0]   lo;
    logic [5:0]    keys;
    logic [3:0]    mode;
    logic          busy;
    logic          typed;
    api_pkg::res_t want;
  } drow_t;

  // quiet result right after reset, volume at the user level
  localparam api_pkg::res_t RES_QUIET = '{buzzer_reinit: 1'b0, sound_level: 3'd3,
                                          inhibit_event: 1'b0, inhibited_display: 1'b0,
                                          led_cmd: api_pkg::LED_OFF,
                                          buzzer_cmd: api_pkg::BUZ_OFF,
                                          new_high_alarm: 1'b0, new_alarm: 1'b0,
                                          any_alarm: 1'b0, prio_level: api_pkg::LVL_NONE};
  // first high alarm from idle: machine only moves to detected, holds stay off
  localparam api_pkg::res_t RES_FIRST_HIGH = '{buzzer_reinit: 1'b0, sound_level: 3'd3,
                                               inhibit_event: 1'b0, inhibited_display: 1'b0,
                                               led_cmd: api_pkg::LED_OFF,
                                               buzzer_cmd: api_pkg::BUZ_OFF,
                                               new_high_alarm: 1'b1, new_alarm: 1'b1,
                                               any_alarm: 1'b1,
                                               prio_level: api_pkg::LVL_HIGH};
  localparam api_pkg::res_t RES_UNTYPED = '0;

  drow_t dir_rows [N_DIR] = '{
    // cancel with no alarm on the very first period, mode seen for the first time
    '{48'h0, 48'h0, 16'h0, K_CANCEL, 4'd9, 1'b0, 1'b1, RES_QUIET},
    // every alarm bit at once
    '{ALL_WORDS, ALL_WORDS, 16'hFFFF, 6'h0, 4'd9, 1'b0, 1'b1, RES_FIRST_HIGH},
    // cancel refused by battery end, then by overheat, ignored on keyboard fault
    '{ALL_WORDS, ALL_WORDS, 16'hFFFF, K_CANCEL | K_BATTERY, 4'd9, 1'b0, 1'b0, RES_UNTYPED},
    '{ALL_WORDS, ALL_WORDS, 16'hFFFF, K_CANCEL | K_OVERHEAT, 4'd9, 1'b0, 1'b0, RES_UNTYPED},
    '{ALL_WORDS, ALL_WORDS, 16'hFFFF, K_CANCEL | K_KBFAULT, 4'd9, 1'b0, 1'b0, RES_UNTYPED},
    // accepted cancel, display dismissed, uncancel, cancel again
    '{ALL_WORDS, ALL_WORDS, 16'hFFFF, K_CANCEL, 4'd9, 1'b0, 1'b0, RES_UNTYPED},
    '{ALL_WORDS, ALL_WORDS, 16'hFFFF, K_DISMISS, 4'd9, 1'b0, 1'b0, RES_UNTYPED},
    '{ALL_WORDS, ALL_WORDS, 16'hFFFF, K_UNCANCEL, 4'd9, 1'b0, 1'b0, RES_UNTYPED},
    '{ALL_WORDS, ALL_WORDS, 16'hFFFF, K_CANCEL, 4'd9, 1'b0, 1'b0, RES_UNTYPED},
    // level drops from high while inhibited
    '{48'h0, ALL_WORDS, 16'hFFFF, K_DISMISS, 4'd9, 1'b0, 1'b0, RES_UNTYPED},
    '{48'h0, 48'h0, 16'h0, K_CANCEL, 4'd9, 1'b0, 1'b0, RES_UNTYPED},
    '{48'h0, 48'h0, 16'h0001, 6'h0, 4'd9, 1'b0, 1'b0, RES_UNTYPED},
    '{48'h0, 48'h0, 16'h8001, 6'h0, 4'd9, 1'b0, 1'b0, RES_UNTYPED},
    '{48'h0, 48'h0001_0000_0000, 16'h8001, 6'h0, 4'd9, 1'b0, 1'b0, RES_UNTYPED},
    // beep sequence overrides the buzzer, then a mode change
    '{48'h0, 48'h0001_0000_0000, 16'h8001, 6'h0, 4'd9, 1'b1, 1'b0, RES_UNTYPED},
    '{48'h0, 48'h0001_0000_0000, 16'h8001, 6'h0, 4'd3, 1'b0, 1'b0, RES_UNTYPED},
    '{48'h8000_0000_0000, 48'h0001_0000_0000, 16'h8001, 6'h0, 4'd3, 1'b0, 1'b0,
      RES_UNTYPED},
    '{48'h8000_0000_0000, 48'h0001_0000_0000, 16'h8001, K_ALL, 4'd15, 1'b1, 1'b0,
      RES_UNTYPED},
    '{48'h0000_0000_0001, 48'h0, 16'h0, K_CANCEL, 4'd15, 1'b0, 1'b0, RES_UNTYPED},
    '{48'h0, 48'h0, 16'h0, 6'h0, 4'd0, 1'b0, 1'b0, RES_UNTYPED}
  };

  // register settings per random phase; the fifth is drawn at random
  api_pkg::cfg_t phase_cfg [N_PHASES] = '{
    '{16'd3, 16'd4, 3'd2, 3'd6},
    '{16'd1, 16'd1, 3'd0, 3'd7},
    '{16'd65535, 16'd65535, 3'd7, 3'd0},
    '{16'd0, 16'd0, 3'd5, 3'd5},
    '{16'd1, 16'd1, 3'd0, 3'd0},
    '{16'd7, 16'd12, 3'd3, 3'd7}
  };

  // dut signals, the driven ones known from time zero
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [3:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  alarm_priority_indication u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // model state, mirrors the block after reset
  // ---------------------------------------------------------------------------
  api_pkg::cfg_t live_cfg = '{16'd60, 16'd60, 3'd3, 3'd7};
  logic [47:0] seen_hi = '0;
  logic [47:0] seen_me = '0;
  logic [15:0] seen_lo = '0;
  logic [1:0]  seen_lvl = api_pkg::LVL_NONE;
  ind_state_t  ind_st = IND_IDLE;
  logic        inh_flag = 1'b0;
  logic        boost_lock = 1'b0;
  logic        boosting = 1'b0;
  logic        mode_known = 1'b0;
  logic [16:0] boost_cnt = api_pkg::TMR_EXPIRED;
  logic [15:0] mute_cnt = '0;
  logic [3:0]  seen_mode = '0;
  logic [2:0]  buz_hold = api_pkg::BUZ_OFF;
  logic [1:0]  led_hold = api_pkg::LED_OFF;

  // scoreboard and bookkeeping
  api_pkg::res_t due_indications [$];
  int   err_cnt = 0;
  int   n_in = 0;
  int   n_out = 0;
  int   n_evt = 0;
  int   n_cfg = 0;
  int   boost_hits = 0;
  int   cyc = 0;

  // stimulus control
  int   sender_idle_pct = 36;
  int   recv_idle_pct = 64;
  int   hold_tickets = 0;
  int   holds_done = 0;
  int   hold_left = 0;

  // random scenario: current words and mode, evolved period by period
  logic [47:0] cur_hi = '0;
  logic [47:0] cur_me = '0;
  logic [15:0] cur_lo = '0;
  logic [3:0]  cur_mode = '0;

  // one scheduling period of the indication logic
  function automatic api_pkg::res_t alarm_period(input api_pkg::in_item_t it);
    api_pkg::res_t r;
    logic [47:0]   hi;
    logic [47:0]   me;
    logic [15:0]   lo;
    logic [1:0]    lvl;
    logic          flag0, det, nw, nwh, took, rein, mchg;
    hi    = it.high_words;
    me    = it.medium_words;
    lo    = it.low_word;
    flag0 = inh_flag;
    took  = 1'b0;
    rein  = 1'b0;

    // timers tick before anything reads them
    if (boost_cnt != api_pkg::TMR_EXPIRED && boost_cnt != api_pkg::TMR_STOPPED)
      boost_cnt = boost_cnt - 17'd1;
    if (mute_cnt != 16'd0) mute_cnt = mute_cnt - 16'd1;

    // first period only learns the mode
    if (!mode_known) begin
      seen_mode  = it.vent_mode;
      mode_known = 1'b1;
    end

    if (hi != 0) begin
      lvl = api_pkg::LVL_HIGH;
    end else begin
      // high gone while volume sits at max: restore the user volume
      if ((boosting ? live_cfg.max_sound_level : live_cfg.user_sound_level)
          == live_cfg.max_sound_level && seen_lvl == api_pkg::LVL_HIGH) begin
        boosting = 1'b0;
        rein     = 1'b1;
      end
      lvl = (me != 0) ? api_pkg::LVL_MEDIUM : (lo != 0) ? api_pkg::LVL_LOW : api_pkg::LVL_NONE;
    end
    det = lvl != api_pkg::LVL_NONE;

    // rising bits against last period
    nwh = (hi & ~seen_hi) != 0;
    nw  = nwh || (me & ~seen_me) != 0 || (lo & ~seen_lo) != 0;
    if (nw) inh_flag = 1'b0;
    seen_hi = hi;
    seen_me = me;
    seen_lo = lo;

    // cancel key, refused without alarm or on battery end / overheat
    if (it.cancel_request && !it.keyboard_fault) begin
      if (det && !it.battery_end && !it.turbine_overheat) begin
        took     = 1'b1;
        inh_flag = 1'b1;
        boosting = 1'b0;
      end
    end else if (!det) begin
      inh_flag = 1'b0;
    end

    // boost timer: restart on new high once expired or stopped, stop on drop or mode change, engage at zero
    mchg      = seen_mode != it.vent_mode;
    seen_mode = it.vent_mode;
    if (nwh && (boost_cnt == api_pkg::TMR_EXPIRED || boost_cnt == api_pkg::TMR_STOPPED)) begin
      boost_cnt  = {1'b0, live_cfg.boost_periods};
      boost_lock = 1'b0;
    end else if ((lvl != api_pkg::LVL_HIGH && seen_lvl == api_pkg::LVL_HIGH) || mchg) begin
      boost_cnt = api_pkg::TMR_STOPPED;
      boosting  = 1'b0;
      rein      = 1'b1;
    end else if (boost_cnt == api_pkg::TMR_EXPIRED && lvl == api_pkg::LVL_HIGH
                 && !took && !boost_lock) begin
      boosting   = 1'b1;
      buz_hold   = api_pkg::BUZ_OFF;
      rein       = 1'b1;
      boost_lock = 1'b1;
      boost_hits++;
    end
    seen_lvl = lvl;

    case (ind_st)
      IND_IDLE: begin
        if (det) begin
          ind_st = IND_ALERT;
        end else begin
          buz_hold = api_pkg::BUZ_OFF;
          led_hold = api_pkg::LED_OFF;
        end
      end
      IND_ALERT: begin
        buz_hold = {1'b0, lvl};
        led_hold = lvl;
        if (!det) begin
          ind_st = IND_IDLE;
        end else if (took) begin
          ind_st   = IND_MUTED;
          mute_cnt = live_cfg.inhibit_periods;
        end
      end
      IND_MUTED: begin
        buz_hold = api_pkg::BUZ_INHIBIT;
        // dismissed display with the flag clear keeps the led unless all quiet
        if (it.display_dismissed && !flag0) begin
          if (!det) led_hold = api_pkg::LED_OFF;
        end else begin
          led_hold = lvl;
        end
        if (!det) begin
          ind_st = IND_IDLE;
        end else if (nw || mute_cnt == 16'd0 || it.uncancel_request) begin
          ind_st   = IND_ALERT;
          inh_flag = 1'b0;
          if (lvl == api_pkg::LVL_HIGH) begin
            boost_cnt  = {1'b0, live_cfg.boost_periods};
            boost_lock = 1'b0;
          end
          rein     = 1'b1;
          boosting = 1'b0;
        end
      end
      default: ;
    endcase

    if (it.start_stop_busy) buz_hold = api_pkg::BUZ_INHIBIT;

    r.prio_level        = lvl;
    r.any_alarm         = det;
    r.new_alarm         = nw;
    r.new_high_alarm    = nwh;
    r.buzzer_cmd        = buz_hold;
    r.led_cmd           = led_hold;
    r.inhibited_display = inh_flag;
    r.inhibit_event     = took;
    r.sound_level       = boosting ? live_cfg.max_sound_level : live_cfg.user_sound_level;
    r.buzzer_reinit     = rein;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch, %s: expected %0h, got %0h", what, want, got);
  endtask

  task automatic cmp_field(input string name, input int unsigned want,
                           input int unsigned got);
    if (want != got) note_mismatch($sformatf("result %0d %s", n_out, name),
                                   64'(want), 64'(got));
  endtask

  // ---------------------------------------------------------------------------
  // scoreboard: result side first, then the input beat of the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sb
    api_pkg::res_t got, want, calc;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = api_pkg::res_t'(out_tdata);
        if (due_indications.size() == 0) begin
          note_mismatch("result beat with nothing pending", 64'd0, 64'(got));
        end else begin
          want = due_indications.pop_front();
          cmp_field("prio_level", 32'(want.prio_level), 32'(got.prio_level));
          cmp_field("any_alarm", 32'(want.any_alarm), 32'(got.any_alarm));
          cmp_field("new_alarm", 32'(want.new_alarm), 32'(got.new_alarm));
          cmp_field("new_high_alarm", 32'(want.new_high_alarm), 32'(got.new_high_alarm));
          cmp_field("buzzer_cmd", 32'(want.buzzer_cmd), 32'(got.buzzer_cmd));
          cmp_field("led_cmd", 32'(want.led_cmd), 32'(got.led_cmd));
          cmp_field("inhibited_display", 32'(want.inhibited_display),
                    32'(got.inhibited_display));
          cmp_field("inhibit_event", 32'(want.inhibit_event), 32'(got.inhibit_event));
          cmp_field("sound_level", 32'(want.sound_level), 32'(got.sound_level));
          cmp_field("buzzer_reinit", 32'(want.buzzer_reinit), 32'(got.buzzer_reinit));
        end
        n_out++;
      end
      if (in_tvalid && in_tready) begin
        calc = alarm_period(api_pkg::in_item_t'(in_tdata));
        if (calc.inhibit_event) n_evt++;
        // hand-written rows override the model
        if (n_in < N_DIR && dir_rows[n_in].typed) calc = dir_rows[n_in].want;
        due_indications.push_back(calc);
        n_in++;
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (holds_done != hold_tickets) begin
      holds_done <= holds_done + 1;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one beat after a random gap and wait for the handshake;
  // valid stays high afterwards so back-to-back beats need no extra edge
  task automatic send_period(input api_pkg::in_item_t it);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    do @(posedge clk); while (!in_tready);
  endtask

  // drop valid and let every pending result come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (due_indications.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // register write, then read back through the same port
  task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
    logic [31:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'h0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      api_pkg::REG_INHIBIT_PERIODS: live_cfg.inhibit_periods = val;
      api_pkg::REG_BOOST_PERIODS:   live_cfg.boost_periods = val;
      api_pkg::REG_USER_SOUND:      live_cfg.user_sound_level = val[2:0];
      api_pkg::REG_MAX_SOUND:       live_cfg.max_sound_level = val[2:0];
      default: ;
    endcase
    want = (idx == api_pkg::REG_USER_SOUND || idx == api_pkg::REG_MAX_SOUND)
           ? {29'h0, val[2:0]} : {16'h0, val};
    // straight into the read setup
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata != want) note_mismatch($sformatf("register %0d readback", idx),
                                          64'(want), 64'(cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    n_cfg++;
  endtask

  // move one alarm word group a step: raise a bit, clear a bit or all, or scramble bits
  function automatic logic [47:0] evolve(input logic [47:0] cur, input int nb);
    logic [63:0] rnd;
    logic [47:0] msk;
    int          k;
    rnd = {$urandom, $urandom};
    msk = (nb == 48) ? ALL_WORDS : 48'hFFFF;
    k   = $urandom_range(nb - 1);
    case ($urandom_range(9))
      0, 1, 2: evolve = cur | (48'd1 << k);
      3, 4:    evolve = cur & ~(48'd1 << k);
      5, 6:    evolve = '0;
      7:       evolve = (rnd[47:0] & 48'hFFFF) << (16 * $urandom_range(nb / 16 - 1));
      default: evolve = rnd[47:0] & msk;
    endcase
  endfunction

  // mostly steady alarm words so timers run out, with keys pressed now and then
  function automatic api_pkg::in_item_t random_period();
    api_pkg::in_item_t it;
    it = '0;
    if ($urandom_range(9) >= 6) begin
      if ($urandom_range(2) == 0) cur_hi = evolve(cur_hi, 48);
      if ($urandom_range(2) == 0) cur_me = evolve(cur_me, 48);
      if ($urandom_range(2) == 0) cur_lo = 16'(evolve({32'h0, cur_lo}, 16));
    end
    if ($urandom_range(29) == 0) cur_mode = 4'($urandom_range(15));
    it.high_words        = cur_hi;
    it.medium_words      = cur_me;
    it.low_word          = cur_lo;
    it.cancel_request    = ($urandom_range(5) == 0);
    it.keyboard_fault    = ($urandom_range(11) == 0);
    it.battery_end       = ($urandom_range(11) == 0);
    it.turbine_overheat  = ($urandom_range(11) == 0);
    it.uncancel_request  = ($urandom_range(15) == 0);
    it.display_dismissed = ($urandom_range(2) == 0);
    it.vent_mode         = cur_mode;
    it.start_stop_busy   = ($urandom_range(9) == 0);
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    api_pkg::in_item_t it;
    api_pkg::cfg_t     c;
    int                ph;
    int                i;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under the reset register values
    for (i = 0; i < N_DIR; i++) begin
      it                   = '0;
      it.high_words        = dir_rows[i].hi;
      it.medium_words      = dir_rows[i].me;
      it.low_word          = dir_rows[i].lo;
      it.cancel_request    = (dir_rows[i].keys & K_CANCEL) != 0;
      it.keyboard_fault    = (dir_rows[i].keys & K_KBFAULT) != 0;
      it.battery_end       = (dir_rows[i].keys & K_BATTERY) != 0;
      it.turbine_overheat  = (dir_rows[i].keys & K_OVERHEAT) != 0;
      it.uncancel_request  = (dir_rows[i].keys & K_UNCANCEL) != 0;
      it.display_dismissed = (dir_rows[i].keys & K_DISMISS) != 0;
      it.vent_mode         = dir_rows[i].mode;
      it.start_stop_busy   = dir_rows[i].busy;
      send_period(it);
    end
    cur_mode = dir_rows[N_DIR - 1].mode;

    // random phases, each under its own register setting and one of three idling mixes
    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      sender_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 64 : 0;
      recv_idle_pct  <= (ph < 2) ? 64 : (ph < 4) ? 36 : 0;
      c = phase_cfg[ph];
      if (ph == 4) begin
        c.inhibit_periods  = 16'($urandom_range(1, 20));
        c.boost_periods    = 16'($urandom_range(1, 20));
        c.user_sound_level = 3'($urandom_range(7));
        c.max_sound_level  = 3'($urandom_range(7));
      end
      reg_write(api_pkg::REG_INHIBIT_PERIODS, c.inhibit_periods);
      reg_write(api_pkg::REG_BOOST_PERIODS, c.boost_periods);
      reg_write(api_pkg::REG_USER_SOUND, {13'h0, c.user_sound_level});
      reg_write(api_pkg::REG_MAX_SOUND, {13'h0, c.max_sound_level});

      for (i = 0; i < PHASE_BEATS; i++) begin
        // long output hold-off while beats keep coming: block fills and backs up
        if ((ph == 0 && i == 60) || (ph == 3 && i == 100) || (ph == 4 && i == 50))
          hold_tickets <= hold_tickets + 1;
        // sender pause until the pipeline is empty
        if (ph == 2 && i == 120) wait_drained();
        send_period(random_period());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("%0d periods over %0d register writes, %0d result beats checked",
             n_in, n_cfg, n_out);
    $display("%0d inhibitions accepted, %0d boost engagements, %0d long output holds",
             n_evt, boost_hits, holds_done);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
